// File: hdl/stpwm_pkg.sv
// Shared types and constants for the slot-table shift-chain PWM block.
package stpwm_pkg;

    typedef struct packed {
        logic       mode;
        logic [5:0] channel;
        logic [7:0] duty;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // paddr[2] selects the register
    localparam logic REG_IDX_COUNT = 1'b0;
    localparam logic REG_IDX_STEPS = 1'b1;

    localparam logic [3:0] RESET_COUNT = 4'd1;
    localparam logic [7:0] RESET_STEPS = 8'd255;

    // level = (duty*steps*2 + 255) / 510; slot t is on when (t+1)*510 <= numerator
    localparam logic [16:0] HALF_SCALE = 17'd510;
    localparam logic [16:0] ROUND_BIAS = 17'd255;

endpackage

// File: hdl/stpwm_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module stpwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2040
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/slot_table_pwm_shift_chain.sv
// Top level: slot-table PWM for a chain of 8-bit shift registers.
// Set item: accept, a prep state (SPREP), then one pipelined read-modify-write per slot;
//   the next item is taken once the last slot is written; one memory read/write pair per slot.
// Tick item: per emitted byte, a RAM read (TREAD), then a load into the output register
//   (TLOAD), which waits while the output is stalled; next item taken after the last byte.
// Reset: clears all MAX_REGISTERS*MAX_STEPS slot-table entries (2040 by default), one
//   entry per cycle, with input ready low; config registers take their reset values.
module slot_table_pwm_shift_chain #(
    parameter int MAX_REGISTERS = 8,
    parameter int MAX_STEPS     = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stpwm_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stpwm_pkg::t_out    o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int Depth  = MAX_REGISTERS * MAX_STEPS;
    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int RegCap = (MAX_REGISTERS < 15) ? MAX_REGISTERS : 15;

    typedef enum logic [5:0] {
        ST_CLR   = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SPREP = 6'b000100,
        ST_SRUN  = 6'b001000,
        ST_TREAD = 6'b010000,
        ST_TLOAD = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]       r_reg_count;
    logic [7:0]       r_steps;
    logic [7:0]       r_slot, n_slot;
    logic [AddrW-1:0] r_caddr, n_caddr;
    logic             r_wvalid, n_wvalid;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_t, n_t;
    logic [3:0]       r_tcnt, n_tcnt;

    logic [AddrW-1:0] r_base, n_base;
    logic [7:0]       r_mask, n_mask;
    logic [15:0]      r_prod, n_prod;
    logic [16:0]      r_x, n_x;
    logic [16:0]      r_acc, n_acc;
    logic [7:0]       r_nsteps, n_nsteps;
    logic [AddrW-1:0] r_waddr, n_waddr;
    logic             r_won, n_won;
    logic [AddrW-1:0] r_taddr, n_taddr;
    stpwm_pkg::t_out  r_out, n_out;

    logic [3:0]       nreg;
    logic [7:0]       nsteps;
    logic             cfg_wr;
    logic             in_fire;
    logic             out_load;
    logic             ram_we, ram_re;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    // effective configuration
    assign nreg = (r_reg_count == 4'd0) ? 4'd1 :
                  ((r_reg_count > 4'(RegCap)) ? 4'(RegCap) : r_reg_count);
    assign nsteps = (r_steps == 8'd0) ? 8'd1 :
                    ((32'(r_steps) > MAX_STEPS) ? 8'(MAX_STEPS) : r_steps);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            stpwm_pkg::REG_IDX_COUNT: prdata = {28'd0, r_reg_count};
            stpwm_pkg::REG_IDX_STEPS: prdata = {24'd0, r_steps};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= stpwm_pkg::RESET_COUNT;
            r_steps     <= stpwm_pkg::RESET_STEPS;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                stpwm_pkg::REG_IDX_COUNT: r_reg_count <= pwdata[3:0];
                stpwm_pkg::REG_IDX_STEPS: r_steps     <= pwdata[7:0];
                default:                  r_steps     <= r_steps;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;
    assign out_load    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_caddr     = r_caddr;
        n_wvalid    = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_t         = r_t;
        n_tcnt      = r_tcnt;
        n_base      = r_base;
        n_mask      = r_mask;
        n_prod      = r_prod;
        n_x         = r_x;
        n_acc       = r_acc;
        n_nsteps    = r_nsteps;
        n_waddr     = r_waddr;
        n_won       = r_won;
        n_taddr     = r_taddr;
        n_out       = r_out;
        ram_re      = 1'b0;
        ram_raddr   = r_taddr;
        ram_we      = 1'b0;
        ram_waddr   = r_waddr;
        ram_wdata   = r_won ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);

        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_caddr;
                ram_wdata = 8'd0;
                n_caddr   = r_caddr + AddrW'(1);
                if (r_caddr == AddrW'(Depth - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.mode == stpwm_pkg::MODE_TICK) begin
                        n_taddr = AddrW'(nreg - 4'd1) * AddrW'(MAX_STEPS) + AddrW'(r_slot);
                        n_tcnt  = nreg;
                        n_slot  = ((r_slot + 8'd1) >= nsteps) ? 8'd0 : r_slot + 8'd1;
                        n_state = ST_TREAD;
                    end else if ({1'b0, i_in_data.channel[5:3]} < nreg) begin
                        n_base   = AddrW'(i_in_data.channel[5:3]) * AddrW'(MAX_STEPS);
                        n_mask   = 8'b1 << i_in_data.channel[2:0];
                        n_prod   = 16'(i_in_data.duty) * 16'(nsteps);
                        n_nsteps = nsteps;
                        n_state  = ST_SPREP;
                    end
                end
            end
            ST_SPREP: begin
                n_x     = {r_prod, 1'b0} + stpwm_pkg::ROUND_BIAS;
                n_acc   = stpwm_pkg::HALF_SCALE;
                n_t     = 8'd0;
                n_state = ST_SRUN;
            end
            ST_SRUN: begin
                ram_we = r_wvalid;
                if (r_t < r_nsteps) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_base + AddrW'(r_t);
                    n_wvalid  = 1'b1;
                    n_waddr   = ram_raddr;
                    n_won     = (r_acc <= r_x);
                    n_t       = r_t + 8'd1;
                    n_acc     = r_acc + stpwm_pkg::HALF_SCALE;
                end else if (r_wvalid) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TREAD: begin
                ram_re  = 1'b1;
                n_state = ST_TLOAD;
            end
            ST_TLOAD: begin
                if (out_load) begin
                    n_out.out_byte  = ram_rdata;
                    n_out.last_byte = (r_tcnt == 4'd1);
                    n_out_valid     = 1'b1;
                    if (r_tcnt == 4'd1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_tcnt  = r_tcnt - 4'd1;
                        n_taddr = r_taddr - AddrW'(MAX_STEPS);
                        n_state = ST_TREAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_slot      <= 8'd0;
            r_caddr     <= '0;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_t         <= 8'd0;
            r_tcnt      <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_caddr     <= n_caddr;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
            r_t         <= n_t;
            r_tcnt      <= n_tcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_mask   <= n_mask;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_nsteps <= n_nsteps;
        r_waddr  <= n_waddr;
        r_won    <= n_won;
        r_taddr  <= n_taddr;
        r_out    <= n_out;
    end

    stpwm_ram #(
        .WIDTH(8),
        .DEPTH(Depth)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_no_write_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TREAD || r_state == ST_TLOAD) |-> !ram_we)
        else $error("table written during tick readout");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (ram_raddr <= AddrW'(Depth - 1)))
        else $error("table read address out of range");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRUN) |-> (r_t <= r_nsteps))
        else $error("set sweep ran past steps");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !r_out_valid)
        else $error("output beat during table clear");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TLOAD && out_load && r_tcnt == 4'd1) |=>
            (r_out_valid && r_out.last_byte && r_state == ST_IDLE))
        else $error("final tick beat not marked last");

endmodule

// File: bench/stpwm_checker.sv
// Checker: watches both streams and the register port, predicts the chain bytes, compares.
module stpwm_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  stpwm_pkg::t_in    i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  stpwm_pkg::t_out   i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS  = 8;
    localparam int NUM_SLOTS = 255;

    logic [7:0]      slot_bytes [NUM_REGS][NUM_SLOTS];
    logic [7:0]      slot_now;
    logic [3:0]      chain_len;
    logic [7:0]      period;
    stpwm_pkg::t_out expected_beats[$];
    int              mismatches;

    task automatic predict_chain_bytes(input stpwm_pkg::t_in item);
        int unsigned     nreg;
        int unsigned     nslot;
        int unsigned     duty;
        int unsigned     level;
        int unsigned     reg_sel;
        int unsigned     cur;
        logic [7:0]      mask;
        stpwm_pkg::t_out beat;
        nreg  = (chain_len == 0) ? 1 : ((chain_len > NUM_REGS) ? NUM_REGS : chain_len);
        nslot = (period == 0) ? 1 : period;
        if (item.mode == stpwm_pkg::MODE_SET) begin
            reg_sel = item.channel[5:3];
            mask    = 8'b1 << item.channel[2:0];
            duty    = item.duty;
            level   = (duty * nslot * 2 + 255) / 510;
            if (reg_sel < nreg) begin
                for (int unsigned t = 0; t < nslot; t++) begin
                    if (t < level)
                        slot_bytes[reg_sel][t] = slot_bytes[reg_sel][t] | mask;
                    else
                        slot_bytes[reg_sel][t] = slot_bytes[reg_sel][t] & ~mask;
                end
            end
        end else begin
            cur = slot_now;
            if (cur >= NUM_SLOTS)
                cur = 0;
            for (int unsigned r = nreg; r > 0; r--) begin
                beat.out_byte  = slot_bytes[r - 1][cur];
                beat.last_byte = (r == 1);
                expected_beats.push_back(beat);
            end
            slot_now = (cur + 1 >= nslot) ? 8'd0 : 8'(cur + 1);
        end
    endtask

    always @(posedge i_clk) begin
        stpwm_pkg::t_out want;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++)
                for (int t = 0; t < NUM_SLOTS; t++)
                    slot_bytes[r][t] = 8'd0;
            slot_now   = 8'd0;
            chain_len  = stpwm_pkg::RESET_COUNT;
            period     = stpwm_pkg::RESET_STEPS;
            mismatches = 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected beat: out_byte %0h last_byte %0b",
                           i_out_data.out_byte, i_out_data.last_byte);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h",
                               want.out_byte, i_out_data.out_byte);
                        mismatches++;
                    end
                    if (i_out_data.last_byte !== want.last_byte) begin
                        $error("last_byte: expected %0b, actual %0b",
                               want.last_byte, i_out_data.last_byte);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_chain_bytes(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == stpwm_pkg::REG_IDX_COUNT)
                    chain_len = i_pwdata[3:0];
                else
                    period = i_pwdata[7:0];
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_beats.size();
    end
endmodule

// File: bench/tb.sv
// Testbench top: stimulus, handshake idling, register setup and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 300;

    logic            i_clk;
    logic            i_rst_n    = 1'b0;
    logic            in_valid   = 1'b0;
    logic            in_ready;
    stpwm_pkg::t_in  in_data    = '0;
    logic            out_valid;
    logic            out_ready  = 1'b1;
    stpwm_pkg::t_out out_data;
    logic            psel       = 1'b0;
    logic            penable    = 1'b0;
    logic            pwrite     = 1'b0;
    logic [2:0]      paddr      = '0;
    logic [31:0]     pwdata     = '0;
    logic [31:0]     prdata;
    logic            pready;
    int              fail_count;
    int              pending;
    int              send_idle  = 0;
    int              recv_stall = 0;
    int              cycle_count = 0;
    int              chain_now  = 1;

    slot_table_pwm_shift_chain uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    stpwm_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall);
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic send_item(input stpwm_pkg::t_in item);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic set_duty(input int ch, input int duty);
        stpwm_pkg::t_in item;
        item.mode    = stpwm_pkg::MODE_SET;
        item.channel = 6'(ch);
        item.duty    = 8'(duty);
        send_item(item);
    endtask

    task automatic tick(input int n);
        stpwm_pkg::t_in item;
        for (int i = 0; i < n; i++) begin
            item.mode    = stpwm_pkg::MODE_TICK;
            item.channel = 6'($urandom);
            item.duty    = 8'($urandom);
            send_item(item);
        end
    endtask

    // wait for every expected beat, then let a pending slot rewrite finish
    task automatic drain_chain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int count, input int steps);
        drain_chain();
        write_reg(stpwm_pkg::REG_IDX_COUNT, 32'(count));
        write_reg(stpwm_pkg::REG_IDX_STEPS, 32'(steps));
        chain_now = (count < 1) ? 1 : ((count > 8) ? 8 : count);
    endtask

    task automatic random_phase(input int count, input int steps, input int n,
                                input int idle, input int stall);
        stpwm_pkg::t_in item;
        configure(count, steps);
        send_idle  = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                drain_chain();
            item.mode    = ($urandom_range(1) == 0) ? stpwm_pkg::MODE_SET
                                                    : stpwm_pkg::MODE_TICK;
            item.channel = ($urandom_range(99) < 15) ? 6'($urandom)
                                                     : 6'($urandom_range(chain_now * 8 - 1));
            case ($urandom_range(9))
                0:       item.duty = 8'd0;
                1:       item.duty = 8'd255;
                default: item.duty = 8'($urandom);
            endcase
            send_item(item);
        end
        send_idle  = 0;
        recv_stall = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!in_ready);

        // full chain, full resolution
        configure(8, 255);
        set_duty(0, 255);
        set_duty(63, 128);
        set_duty(7, 1);
        set_duty(56, 255);
        set_duty(56, 0);
        tick(2);
        // short chain: channel beyond it is dropped, slot wraps
        configure(2, 4);
        set_duty(40, 255);
        set_duty(9, 128);
        tick(5);
        // zero count and zero steps act as one
        configure(0, 0);
        set_duty(3, 200);
        set_duty(8, 255);
        tick(2);
        // count above range, then steps lowered under the current slot
        configure(15, 255);
        tick(5);
        configure(8, 2);
        tick(3);

        random_phase(1,   1,   32, 0,  0);
        random_phase(8,   255, 32, 52, 0);
        random_phase(3,   7,   32, 0,  52);
        random_phase(15,  16,  32, 28, 28);
        random_phase(5,   3,   32, 0,  0);
        random_phase(8,   200, 32, 52, 0);
        random_phase(2,   12,  32, 0,  52);
        random_phase(0,   255, 32, 28, 28);

        drain_chain();
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
